@@ src/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared sizes, operation and status codes, and the item and result types.
// ----------------------------------------------------------------------------
package tts_pkg;

	// Size of the task table and the most results one dispatch may give.
	localparam int NUM_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Operation codes.
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_DISP = 2'd2;
	localparam logic [1:0] OP_DEL  = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_TICK      = 3'd2;
	localparam logic [2:0] ST_RUN       = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;
	localparam logic [2:0] ST_DELETED   = 3'd5;
	localparam logic [2:0] ST_DEL_EMPTY = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] first_delay;
		logic [31:0] run_period;
		logic [3:0]  slot_sel;
	} tts_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot_id;
		logic       last;
	} tts_result_t;

endpackage

@@ src/tick_task_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Tick task scheduler
// Table of task slots with add, tick, dispatch and delete operations, worked
// one slot per cycle unless results stall, via a single shared update unit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_stall      tts_item_t
//  result    out        result_valid / result_stall  tts_result_t
//
//  Delete works only on its selected slot. Add walks to the lowest free slot,
//  and tick and dispatch walk the whole slot table, one slot per cycle while
//  the result side does not stall. Every item also waits out the cycles the
//  result side stalls, in its closing step and, for dispatch, at a ready slot
//  while the previous run result cannot move on. Reset clears every valid
//  flag at once; no clearing pass is needed. item_stall is high while an
//  item is being worked. A result waiting in the output register does not
//  hold off the next item.
//
module tick_task_scheduler_top
	import tts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  tts_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output tts_result_t result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	// Sequencer and work registers.
	logic [1:0]       state_q, state_d;
	tts_item_t        cmd_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic             pend_valid_q, pend_valid_d;
	logic [3:0]       pend_slot_q, pend_slot_d;
	logic [2:0]       res_status_q, res_status_d;
	logic [3:0]       res_slot_q, res_slot_d;

	// Output register.
	logic        out_valid_q, out_valid_d;
	tts_result_t out_q, out_d;

	// Slot table.
	logic [NUM_SLOTS-1:0] valid_q, valid_d;
	logic [31:0]          delay_q [NUM_SLOTS];
	logic [31:0]          period_q [NUM_SLOTS];
	logic [7:0]           runs_q [NUM_SLOTS];

	// Write port of the slot fields, always at the walk index.
	logic        wr_en;
	logic [31:0] wr_delay, wr_period;
	logic [7:0]  wr_runs;

	logic [31:0]      rd_delay, rd_period;
	logic [7:0]       rd_runs;
	logic             rd_valid;
	logic             out_free;
	logic             at_end;
	logic [IDX_W-1:0] sel_idx;
	logic             sel_in_range;
	logic             fire;

	assign rd_delay     = delay_q[idx_q];
	assign rd_period    = period_q[idx_q];
	assign rd_runs      = runs_q[idx_q];
	assign rd_valid     = valid_q[idx_q];
	assign out_free     = !out_valid_q || !result_stall;
	assign at_end       = (idx_q == LAST_IDX);
	assign sel_idx      = IDX_W'(cmd_q.slot_sel);
	assign sel_in_range = ({28'd0, cmd_q.slot_sel} < 32'(NUM_SLOTS));
	assign fire         = rd_valid && (rd_runs != 8'd0) && (n_q < CNT_W'(MAX_RESULTS));

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Sequencer and the shared per-slot update unit.
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		n_d          = n_q;
		pend_valid_d = pend_valid_q;
		pend_slot_d  = pend_slot_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		valid_d      = valid_q;
		wr_en        = 1'b0;
		wr_delay     = rd_delay;
		wr_period    = rd_period;
		wr_runs      = rd_runs;
		out_valid_d  = out_valid_q && result_stall;
		out_d        = out_q;

		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d      = S_WALK;
					idx_d        = '0;
					n_d          = '0;
					pend_valid_d = 1'b0;
				end
			end
			S_WALK: begin
				case (cmd_q.op)
					OP_ADD: begin
						if (!rd_valid) begin
							valid_d[idx_q] = 1'b1;
							wr_en          = 1'b1;
							wr_delay       = cmd_q.first_delay;
							wr_period      = cmd_q.run_period;
							wr_runs        = 8'd0;
							res_status_d   = ST_ADDED;
							res_slot_d     = 4'(idx_q);
							state_d        = S_FIN;
						end else if (at_end) begin
							res_status_d = ST_FULL;
							res_slot_d   = 4'd0;
							state_d      = S_FIN;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					OP_TICK: begin
						// Count the delay down, or reload it and owe one more run.
						if (rd_valid) begin
							wr_en = 1'b1;
							if (rd_delay != 32'd0) begin
								wr_delay = rd_delay - 32'd1;
							end else begin
								wr_delay = rd_period;
								if (rd_runs != 8'hFF) begin
									wr_runs = rd_runs + 8'd1;
								end
							end
						end
						if (at_end) begin
							res_status_d = ST_TICK;
							res_slot_d   = 4'd0;
							state_d      = S_FIN;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					OP_DISP: begin
						// A ready slot waits while an older run result cannot move on.
						if (!(fire && pend_valid_q && !out_free)) begin
							if (fire) begin
								if (pend_valid_q) begin
									out_valid_d = 1'b1;
									out_d       = '{status: ST_RUN, slot_id: pend_slot_q,
										last: 1'b0};
								end
								pend_valid_d = 1'b1;
								pend_slot_d  = 4'(idx_q);
								n_d          = n_q + 1'b1;
								wr_en        = 1'b1;
								wr_runs      = rd_runs - 8'd1;
								if (rd_period == 32'd0) begin
									valid_d[idx_q] = 1'b0;
								end
							end
							if (at_end) begin
								// The last run found is held back so it can carry last.
								if (pend_valid_d) begin
									res_status_d = ST_RUN;
									res_slot_d   = pend_slot_d;
								end else begin
									res_status_d = ST_NONE;
									res_slot_d   = 4'd0;
								end
								pend_valid_d = 1'b0;
								state_d      = S_FIN;
							end else begin
								idx_d = idx_q + 1'b1;
							end
						end
					end
					default: begin
						if (sel_in_range && valid_q[sel_idx]) begin
							res_status_d = ST_DELETED;
						end else begin
							res_status_d = ST_DEL_EMPTY;
						end
						if (sel_in_range) begin
							valid_d[sel_idx] = 1'b0;
						end
						res_slot_d = cmd_q.slot_sel;
						state_d    = S_FIN;
					end
				endcase
			end
			S_FIN: begin
				// Hand the closing result of the item to the output register.
				if (out_free) begin
					out_valid_d = 1'b1;
					out_d       = '{status: res_status_q, slot_id: res_slot_q, last: 1'b1};
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			valid_q      <= '0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
			valid_q      <= valid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			cmd_q <= item;
		end
		idx_q        <= idx_d;
		n_q          <= n_d;
		pend_slot_q  <= pend_slot_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		out_q        <= out_d;
	end

	// Slot fields; a slot that is not valid is never read for its fields.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			delay_q[idx_q]  <= wr_delay;
			period_q[idx_q] <= wr_period;
			runs_q[idx_q]   <= wr_runs;
		end
	end

endmodule

@@ src/tts_checker.sv @@
// ----------------------------------------------------------------------------
// Tick task scheduler checker
// Port-level assertions on the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tts_checker
	import tts_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input tts_result_t result
);

	// A stalled result stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// An accepted item keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block took a second item right after a transfer");

	// Only run results may be followed by more results of the same item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_RUN |-> result.last)
		else $error("single result without last");

	// Full table, tick and empty dispatch report slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_FULL || result.status == ST_TICK ||
			result.status == ST_NONE) |-> result.slot_id == 4'd0)
		else $error("nonzero slot on a slotless result");

endmodule

bind tick_task_scheduler_top tts_checker u_tts_checker (.*);

@@ tb/sv/tb_tick_task_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Tick task scheduler testbench
// Feeds add, tick, dispatch and delete items through the item channel and
// checks every result against a cycle-free copy of the task table. Both
// channels idle at random, and the result side holds off once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_tick_task_scheduler_top;
	import tts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;

	// One queued item, optionally held back until the scheduler has gone quiet.
	typedef struct {
		tts_item_t it;
		bit        drain;
	} sched_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	tts_item_t   item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	tts_result_t result;

	sched_req_t  item_queue[$];
	tts_result_t exp_results[$];

	// Shadow copy of the task table.
	bit          live[NUM_SLOTS];
	logic [31:0] countdown[NUM_SLOTS];
	logic [31:0] reload[NUM_SLOTS];
	logic [7:0]  owed[NUM_SLOTS];

	logic item_sent = 1'b0;
	int   burst_left = 4;
	int   gap_left = 0;
	int   rx_cycle = 0;
	int   long_hold_left = 0;
	bit   long_hold_done = 0;
	int   cycle_count = 0;
	int   results_seen = 0;
	int   errors = 0;
	int   ops_done[4];
	int   status_seen[8];

	tick_task_scheduler_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Clear one slot of the shadow table.
	function automatic void free_slot(input int s);
		live[s]      = 0;
		countdown[s] = '0;
		reload[s]    = '0;
		owed[s]      = '0;
	endfunction

	function automatic tts_result_t mk_result(input logic [2:0] status, input int s,
			input logic last);
		tts_result_t r;
		r.status  = status;
		r.slot_id = 4'(s);
		r.last    = last;
		return r;
	endfunction

	// Apply one accepted item to the shadow table and queue the results it causes.
	function automatic void sched_predict(input tts_item_t it);
		int          s;
		int          n;
		bit          found;
		tts_result_t held;
		n     = 0;
		found = 0;
		held  = '0;
		case (it.op)
			OP_ADD: begin
				for (s = 0; s < NUM_SLOTS && !found; s++) begin
					if (!live[s]) begin
						live[s]      = 1;
						countdown[s] = it.first_delay;
						reload[s]    = it.run_period;
						owed[s]      = '0;
						found        = 1;
						exp_results.push_back(mk_result(ST_ADDED, s, 1'b1));
					end
				end
				if (!found)
					exp_results.push_back(mk_result(ST_FULL, 0, 1'b1));
			end
			OP_TICK: begin
				for (s = 0; s < NUM_SLOTS; s++) begin
					if (live[s]) begin
						if (countdown[s] != 32'd0) begin
							countdown[s] = countdown[s] - 32'd1;
						end else begin
							countdown[s] = reload[s];
							if (owed[s] != 8'hFF)
								owed[s] = owed[s] + 8'd1;
						end
					end
				end
				exp_results.push_back(mk_result(ST_TICK, 0, 1'b1));
			end
			OP_DISP: begin
				// Each run result is held one step so the final one can carry last.
				for (s = 0; s < NUM_SLOTS && n < MAX_RESULTS; s++) begin
					if (live[s] && owed[s] != 8'd0) begin
						if (n > 0)
							exp_results.push_back(held);
						owed[s] = owed[s] - 8'd1;
						held    = mk_result(ST_RUN, s, 1'b0);
						n++;
						if (reload[s] == 32'd0)
							free_slot(s);
					end
				end
				if (n == 0) begin
					exp_results.push_back(mk_result(ST_NONE, 0, 1'b1));
				end else begin
					held.last = 1'b1;
					exp_results.push_back(held);
				end
			end
			default: begin
				if (live[it.slot_sel])
					exp_results.push_back(mk_result(ST_DELETED, it.slot_sel, 1'b1));
				else
					exp_results.push_back(mk_result(ST_DEL_EMPTY, it.slot_sel, 1'b1));
				free_slot(it.slot_sel);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= 20)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [31:0] delay_val,
			input logic [31:0] period_val, input logic [3:0] sel, input bit drain);
		sched_req_t req;
		req.it.op          = op;
		req.it.first_delay = delay_val;
		req.it.run_period  = period_val;
		req.it.slot_sel    = sel;
		req.drain          = drain;
		item_queue.push_back(req);
	endtask

	// Mostly small delays and periods so tasks come due, with the extremes mixed in.
	function automatic logic [31:0] pick_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 3);
		else if (roll < 85)
			return $urandom();
		else if (roll < 95)
			return 32'hFFFF_FFFF;
		else
			return $urandom_range(4, 40);
	endfunction

	// Item driver: offers queued items in bursts with random gaps in between.
	always @(negedge clk) begin : item_driver
		logic offer;
		offer = item_valid;
		if (arst_n) begin
			if (item_sent) begin
				void'(item_queue.pop_front());
				offer = 1'b0;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (item_queue.size() != 0 &&
						(!item_queue[0].drain || exp_results.size() == 0)) begin
					offer = 1'b1;
					item <= item_queue[0].it;
				end
			end
		end
		item_valid <= offer;
	end

	// Result receiver: stalls on a rotating pattern, with one long hold-off.
	always @(negedge clk) begin : result_receiver
		logic hold;
		int   rx_mode;
		rx_cycle++;
		rx_mode = (rx_cycle / 128) % 3;
		if (long_hold_left > 0) begin
			long_hold_left--;
			hold = 1'b1;
		end else if (!long_hold_done && results_seen >= 60) begin
			long_hold_done = 1;
			long_hold_left = LONG_HOLD;
			hold = 1'b1;
		end else begin
			case (rx_mode)
				0: hold = 1'b0;
				1: hold = ($urandom_range(0, 1) == 0);
				default: hold = ($urandom_range(0, 3) != 0);
			endcase
		end
		result_stall <= hold;
	end

	// Monitor: checks each result transfer, then predicts from each item transfer.
	always @(posedge clk) begin : result_monitor
		tts_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, exp_results.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			if (arst_n && result_valid && !result_stall) begin
				results_seen++;
				status_seen[result.status]++;
				if (exp_results.size() == 0) begin
					errors++;
					if (errors <= 20)
						$display("%0t: unexpected result, expected none, actual status %0d slot %0d",
							$time, result.status, result.slot_id);
				end else begin
					want = exp_results.pop_front();
					check_field("status", want.status, result.status);
					check_field("slot_id", want.slot_id, result.slot_id);
					check_field("last", want.last, result.last);
				end
			end
			if (arst_n && item_valid && !item_stall) begin
				ops_done[item.op]++;
				sched_predict(item);
			end
			item_sent <= arst_n && item_valid && !item_stall;
		end
	end

	initial begin : stimulus
		int k;
		int roll;
		int s;
		for (s = 0; s < NUM_SLOTS; s++)
			free_slot(s);

		// Directed: empty table cases, extreme fields, a full table, then runs.
		queue_item(OP_DEL, '0, '0, 4'd15, 0);
		queue_item(OP_DISP, '0, '0, 4'd0, 0);
		queue_item(OP_TICK, '0, '0, 4'd0, 0);
		queue_item(OP_ADD, 32'd0, 32'd0, 4'd0, 0);
		queue_item(OP_ADD, 32'd0, 32'hFFFF_FFFF, 4'd0, 0);
		queue_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 0);
		queue_item(OP_ADD, 32'hFFFF_FFFF, 32'd0, 4'd0, 0);
		for (k = 4; k < NUM_SLOTS; k++)
			queue_item(OP_ADD, k % 3, k % 4, 4'(k), 0);
		queue_item(OP_ADD, 32'd1, 32'd1, 4'd0, 0);
		// Two ticks leave the one-shot in slot 0 owing two runs.
		queue_item(OP_TICK, '0, '0, 4'd0, 0);
		queue_item(OP_TICK, '0, '0, 4'd0, 0);
		queue_item(OP_DISP, '0, '0, 4'd0, 0);
		queue_item(OP_DEL, '0, '0, 4'd1, 0);
		queue_item(OP_ADD, 32'd2, 32'd3, 4'd0, 0);
		queue_item(OP_DISP, '0, '0, 4'd0, 0);

		// Random: task lifecycles with mostly short delays so dispatches find work.
		for (k = 0; k < 144; k++) begin
			roll = $urandom_range(0, 99);
			queue_item((roll < 28) ? OP_ADD : (roll < 60) ? OP_TICK :
				(roll < 88) ? OP_DISP : OP_DEL, pick_word(), pick_word(),
				4'($urandom_range(0, 15)), (k == 0) || ($urandom_range(0, 24) == 0));
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (item_queue.size() != 0 || item_valid)
			@(posedge clk);
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Items: %0d add, %0d tick, %0d dispatch, %0d delete; %0d results checked.",
			ops_done[OP_ADD], ops_done[OP_TICK], ops_done[OP_DISP], ops_done[OP_DEL],
			results_seen);
		$display("Seen: %0d task runs, %0d full-table adds, %0d idle dispatches, %0d empty deletes.",
			status_seen[ST_RUN], status_seen[ST_FULL], status_seen[ST_NONE],
			status_seen[ST_DEL_EMPTY]);
		if (errors == 0 && exp_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, exp_results.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
